// ===== sv/mfb_pkg.sv =====
// Shared definitions for the monochrome frame buffer drawing engine.
// Holds action and color codes, size defaults, the access request word and the pixel update.
// Depends on nothing.
`default_nettype none
package mfb_pkg;

	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;

	localparam logic [2:0] ACT_PIXEL = 3'd0;
	localparam logic [2:0] ACT_HLINE = 3'd1;
	localparam logic [2:0] ACT_VLINE = 3'd2;
	localparam logic [2:0] ACT_CLEAR = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic [1:0] COLOR_BLACK  = 2'd0;
	localparam logic [1:0] COLOR_WHITE  = 2'd1;
	localparam logic [1:0] COLOR_INVERT = 2'd2;

	localparam logic [7:0] MASK_ALL = 8'hFF;

	typedef struct packed {
		logic       clr;
		logic       rmw;
		logic       rd;
		logic       oob;
		logic       fin;
		logic [7:0] mask;
		logic [1:0] color;
	} req_t;

	function automatic logic [7:0] paint(input logic [7:0] data, input logic [7:0] mask,
		input logic [1:0] color);
		logic [7:0] res;
		case (color)
			COLOR_BLACK:  res = data & ~mask;
			COLOR_WHITE:  res = data | mask;
			COLOR_INVERT: res = data ^ mask;
			default:      res = data;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mfb_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Used for the frame store; depends on nothing.
`default_nettype none
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/mfb_seq.sv =====
// Command sequencer: clips each drawing command and walks the store bytes it touches.
// Issues one store access per cycle to the top level while it walks a command's bytes; depends on mfb_pkg.
`default_nettype none
module mfb_seq #(
	parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT,
	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8,
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic        [2:0]  action,
	input  wire logic signed [15:0] x,
	input  wire logic signed [15:0] y,
	input  wire logic signed [15:0] length,
	input  wire logic        [1:0]  color,
	input  wire logic        [9:0]  byte_index,
	output logic                    active,
	output mfb_pkg::req_t           req,
	output logic             [AW-1:0] req_addr
);
	import mfb_pkg::*;

	localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int XW = $clog2(SCREEN_WIDTH);
	localparam int CW = $clog2(SCREEN_WIDTH + 1);
	localparam logic signed [17:0] WS = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] HS = 18'(SCREEN_HEIGHT);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SETUP = 6'b000010,
		S_HWALK = 6'b000100,
		S_VWALK = 6'b001000,
		S_CLEAR = 6'b010000,
		S_READ  = 6'b100000
	} state_t;

	state_t state_q;
	logic report_q;
	logic [AW-1:0] addr_q;

	logic        [2:0]  act_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic signed [15:0] len_q;
	logic        [1:0]  color_q;
	logic        [9:0]  bidx_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pg_q;
	logic [PW-1:0] ep_q;
	logic          first_q;
	logic          oob_q;
	logic [7:0]    mask_lo_q;
	logic [7:0]    mask_hi_q;

	logic signed [17:0] len_eff, h_sx, h_ex_raw, h_ex, h_cnt;
	logic signed [17:0] v_sy, v_ey_raw, v_ey, v_eym1;
	logic y_ok, x_ok, h_draw, v_draw, v_last, oob;
	logic [AW-1:0] h_addr, v_addr;

	always_comb begin
		len_eff  = (act_q == ACT_PIXEL) ? 18'sd1 : 18'(len_q);
		y_ok     = !y_q[15] && (18'(y_q) < HS);
		x_ok     = !x_q[15] && (18'(x_q) < WS);
		h_sx     = x_q[15] ? 18'sd0 : 18'(x_q);
		h_ex_raw = 18'(x_q) + len_eff;
		h_ex     = (h_ex_raw > WS) ? WS : h_ex_raw;
		h_draw   = y_ok && (h_ex > h_sx);
		h_cnt    = h_ex - h_sx;
		v_sy     = y_q[15] ? 18'sd0 : 18'(y_q);
		v_ey_raw = 18'(y_q) + 18'(len_q);
		v_ey     = (v_ey_raw > HS) ? HS : v_ey_raw;
		v_draw   = x_ok && (v_ey > v_sy);
		v_eym1   = v_ey - 18'sd1;
		h_addr   = AW'(int'(y_q[PW+2:3]) * SCREEN_WIDTH + int'(h_sx[XW-1:0]));
		v_addr   = AW'(int'(v_sy[PW+2:3]) * SCREEN_WIDTH + int'(x_q[XW-1:0]));
		oob      = int'(bidx_q) >= STORE_BYTES;
		v_last   = (pg_q == ep_q);
	end

	assign active = (state_q != S_IDLE);

	always_comb begin
		req       = '0;
		req.color = color_q;
		req_addr  = addr_q;
		case (state_q)
			S_SETUP: begin
				case (act_q)
					ACT_PIXEL, ACT_HLINE: req.fin = !h_draw;
					ACT_VLINE:            req.fin = !v_draw;
					ACT_CLEAR, ACT_READ:  req.fin = 1'b0;
					default:              req.fin = 1'b1;
				endcase
			end
			S_HWALK: begin
				req.rmw  = 1'b1;
				req.mask = mask_lo_q;
				req.fin  = (cnt_q == CW'(1));
			end
			S_VWALK: begin
				req.rmw  = 1'b1;
				req.mask = (first_q ? mask_lo_q : MASK_ALL) & (v_last ? mask_hi_q : MASK_ALL);
				req.fin  = v_last;
			end
			S_CLEAR: begin
				req.clr = 1'b1;
				req.fin = report_q && (addr_q == AW'(STORE_BYTES - 1));
			end
			S_READ: begin
				req.rd  = 1'b1;
				req.oob = oob_q;
				req.fin = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			report_q <= 1'b0;
			addr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					case (act_q)
						ACT_PIXEL, ACT_HLINE: begin
							addr_q  <= h_addr;
							state_q <= h_draw ? S_HWALK : S_IDLE;
						end
						ACT_VLINE: begin
							addr_q  <= v_addr;
							state_q <= v_draw ? S_VWALK : S_IDLE;
						end
						ACT_CLEAR: begin
							addr_q   <= '0;
							report_q <= 1'b1;
							state_q  <= S_CLEAR;
						end
						ACT_READ: begin
							addr_q  <= AW'(bidx_q);
							state_q <= S_READ;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_HWALK: begin
					addr_q <= addr_q + AW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_VWALK: begin
					addr_q <= addr_q + AW'(SCREEN_WIDTH);
					if (v_last) begin
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			x_q     <= x;
			y_q     <= y;
			len_q   <= length;
			color_q <= color;
			bidx_q  <= byte_index;
		end
		case (state_q)
			S_SETUP: begin
				cnt_q   <= h_cnt[CW-1:0];
				first_q <= 1'b1;
				oob_q   <= oob;
				if (act_q == ACT_VLINE) begin
					pg_q      <= v_sy[PW+2:3];
					ep_q      <= v_eym1[PW+2:3];
					mask_lo_q <= MASK_ALL << v_sy[2:0];
					mask_hi_q <= MASK_ALL >> (3'd7 - v_eym1[2:0]);
				end else begin
					mask_lo_q <= 8'(1) << y_q[2:0];
					mask_hi_q <= MASK_ALL;
				end
			end
			S_HWALK: cnt_q <= cnt_q - CW'(1);
			S_VWALK: begin
				pg_q    <= pg_q + PW'(1);
				first_q <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/mono_framebuffer_draw_engine.sv =====
// Top level of the monochrome frame buffer drawing engine: frame store RAM, write-back stage
// and result register. Depends on mfb_pkg, mfb_ram and mfb_seq.
//
//   Channel   Handshake          Word
//   command   start / busy       action, x, y, length, color, byte_index
//   result    done (one cycle)   read_data, read_valid
//
// A command passes a setup state, then makes one store access per cycle for each byte it
// touches; its last access goes through the write-back stage, then the result register. Clears,
// commands that draw nothing and unused actions skip the write-back stage. The single RAM port
// pair sets the rate of one byte a cycle. After reset the store is cleared, one byte a cycle,
// with busy high. Results are never held off; done is high for one cycle per command.
`default_nettype none
module mono_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [2:0]  action,
	input  wire logic signed [15:0] x,
	input  wire logic signed [15:0] y,
	input  wire logic signed [15:0] length,
	input  wire logic        [1:0]  color,
	input  wire logic        [9:0]  byte_index,
	output logic                    done,
	output logic             [7:0]  read_data,
	output logic                    read_valid
);
	import mfb_pkg::*;

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW = $clog2(STORE_BYTES);

	logic          active;
	req_t          req;
	logic [AW-1:0] req_addr;
	req_t          pend_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    rdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	assign busy = active || pend_s1.rmw || pend_s1.rd;

	mfb_seq #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.action    (action),
		.x         (x),
		.y         (y),
		.length    (length),
		.color     (color),
		.byte_index(byte_index),
		.active    (active),
		.req       (req),
		.req_addr  (req_addr)
	);

	assign we    = req.clr || pend_s1.rmw;
	assign waddr = req.clr ? req_addr : addr_s1;
	assign wdata = req.clr ? 8'h00 : paint(rdata, pend_s1.mask, pend_s1.color);

	mfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(req_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1    <= '0;
			done       <= 1'b0;
			read_data  <= 8'h00;
			read_valid <= 1'b0;
		end else begin
			pend_s1    <= req;
			done       <= (req.fin && !req.rmw && !req.rd)
				|| (pend_s1.fin && (pend_s1.rmw || pend_s1.rd));
			read_valid <= pend_s1.rd;
			read_data  <= (pend_s1.rd && !pend_s1.oob) ? rdata : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= req_addr;
	end

endmodule
`default_nettype wire

// ===== verif/mono_framebuffer_draw_engine_tb.sv =====
// Self-checking testbench for the monochrome frame buffer drawing engine: directed and random
// drawing and read commands, checked word by word against a local model of the frame store.
// Depends on mfb_pkg and mono_framebuffer_draw_engine.
`default_nettype none
module mono_framebuffer_draw_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCR_W       = mfb_pkg::DEF_SCREEN_WIDTH;
	localparam int SCR_H       = mfb_pkg::DEF_SCREEN_HEIGHT;
	localparam int PAGES       = (SCR_H + 7) / 8;
	localparam int STORE_BYTES = SCR_W * PAGES;
	localparam int RANDOM_CMDS = 1250;
	localparam int STALL_LIMIT = 8 * STORE_BYTES + 1000;
	localparam int TAIL_CYCLES = 20;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam logic [1:0] COLOR_NONE    = 2'd3;

	typedef struct {
		logic        [2:0]  act;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] len;
		logic        [1:0]  col;
		logic        [9:0]  idx;
		bit                 settle;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
	} read_word_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic        [2:0]  action     = '0;
	logic signed [15:0] x          = '0;
	logic signed [15:0] y          = '0;
	logic signed [15:0] length     = '0;
	logic        [1:0]  color      = '0;
	logic        [9:0]  byte_index = '0;
	logic               busy;
	logic               done;
	logic        [7:0]  read_data;
	logic               read_valid;

	logic [7:0] pix_store [STORE_BYTES];
	draw_cmd_t  cmd_queue [$];
	read_word_t read_expect [$];
	draw_cmd_t  in_flight;
	int         burst_left = 1;
	int         gap_left = 0;
	int         mismatch_count = 0;
	int         stall_cycles = 0;
	logic       launch;
	read_word_t seen;

	mono_framebuffer_draw_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.x(x),
		.y(y),
		.length(length),
		.color(color),
		.byte_index(byte_index),
		.done(done),
		.read_data(read_data),
		.read_valid(read_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void touch_byte(input int bidx, input logic [7:0] mask,
		input logic [1:0] col);
		if (bidx < 0 || bidx >= STORE_BYTES)
			return;
		case (col)
			mfb_pkg::COLOR_BLACK:  pix_store[bidx] = pix_store[bidx] & ~mask;
			mfb_pkg::COLOR_WHITE:  pix_store[bidx] = pix_store[bidx] | mask;
			mfb_pkg::COLOR_INVERT: pix_store[bidx] = pix_store[bidx] ^ mask;
			default: ;
		endcase
	endfunction

	function automatic void draw_row(input int cx, input int cy, input int len,
		input logic [1:0] col);
		int         first;
		int         last;
		logic [7:0] mask;
		if (cy < 0 || cy >= SCR_H)
			return;
		first = (cx < 0) ? 0 : cx;
		last  = cx + len;
		if (last > SCR_W)
			last = SCR_W;
		mask = 8'h01 << (cy % 8);
		for (int c = first; c < last; c++)
			touch_byte((cy / 8) * SCR_W + c, mask, col);
	endfunction

	function automatic void draw_column(input int cx, input int cy, input int len,
		input logic [1:0] col);
		int         first;
		int         last;
		int         lo;
		int         hi;
		logic [7:0] mask;
		if (cx < 0 || cx >= SCR_W)
			return;
		first = (cy < 0) ? 0 : cy;
		last  = cy + len;
		if (last > SCR_H)
			last = SCR_H;
		if (last <= first)
			return;
		for (int p = first / 8; p <= (last - 1) / 8; p++) begin
			lo   = ((first > p * 8) ? first : p * 8) - p * 8;
			hi   = ((last < p * 8 + 8) ? last : p * 8 + 8) - p * 8;
			mask = (8'hFF << lo) & (8'hFF >> (8 - hi));
			touch_byte(p * SCR_W + cx, mask, col);
		end
	endfunction

	function automatic void apply_command(input draw_cmd_t c);
		int         cx;
		int         cy;
		int         len;
		read_word_t w;
		cx      = c.px;
		cy      = c.py;
		len     = c.len;
		w.data  = '0;
		w.valid = 1'b0;
		case (c.act)
			mfb_pkg::ACT_PIXEL:
				if (cx >= 0 && cx < SCR_W && cy >= 0 && cy < SCR_H)
					touch_byte((cy / 8) * SCR_W + cx, 8'h01 << (cy % 8), c.col);
			mfb_pkg::ACT_HLINE: draw_row(cx, cy, len, c.col);
			mfb_pkg::ACT_VLINE: draw_column(cx, cy, len, c.col);
			mfb_pkg::ACT_CLEAR: begin
				foreach (pix_store[i])
					pix_store[i] = '0;
			end
			mfb_pkg::ACT_READ: begin
				w.valid = 1'b1;
				if (c.idx < STORE_BYTES)
					w.data = pix_store[c.idx];
			end
			default: ;
		endcase
		read_expect.push_back(w);
	endfunction

	function automatic void add_cmd(input logic [2:0] act, input int px, input int py,
		input int len, input logic [1:0] col, input int idx, input bit settle);
		draw_cmd_t c;
		c.act    = act;
		c.px     = 16'(px);
		c.py     = 16'(py);
		c.len    = 16'(len);
		c.col    = col;
		c.idx    = 10'(idx);
		c.settle = settle;
		cmd_queue.push_back(c);
	endfunction

	function automatic int rand_span(input int lo, input int hi);
		logic signed [15:0] raw;
		if ($urandom_range(0, 9) == 0) begin
			raw = 16'($urandom);
			return raw;
		end
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	task automatic note_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	// The sender holds start while busy is high and never lowers it in the step it raises it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!(start && busy)) begin
			if (start) begin
				apply_command(in_flight);
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
				end
			end
			launch = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (cmd_queue.size() > 0 && !(cmd_queue[0].settle && read_expect.size() > 0))
				launch = 1'b1;
			if (launch) begin
				in_flight = cmd_queue.pop_front();
				start      <= 1'b1;
				action     <= in_flight.act;
				x          <= in_flight.px;
				y          <= in_flight.py;
				length     <= in_flight.len;
				color      <= in_flight.col;
				byte_index <= in_flight.idx;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (read_expect.size() == 0) begin
				note_mismatch("word with nothing pending", 0, read_data);
			end else begin
				seen = read_expect.pop_front();
				if (read_data !== seen.data)
					note_mismatch("read_data", seen.data, read_data);
				if (read_valid !== seen.valid)
					note_mismatch("read_valid", seen.valid, read_valid);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int         r;
		logic [2:0] act;
		logic [1:0] col;
		foreach (pix_store[i])
			pix_store[i] = '0;

		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, 0, 0, 0, mfb_pkg::COLOR_WHITE, 1023, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, SCR_W - 1, SCR_H - 1, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_READ, -1, -1, -1, COLOR_NONE, 0, 0);
		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_WHITE, STORE_BYTES - 1, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, -1, 5, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, SCR_W, 5, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, 5, SCR_H, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, -32768, 32767, 0, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, -10, 9, 20, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, 3, 9, 0, mfb_pkg::COLOR_INVERT, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, 3, 9, -32768, mfb_pkg::COLOR_INVERT, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, 0, -1, 50, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, 0, SCR_H, 50, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, SCR_W - 8, 20, 32767, mfb_pkg::COLOR_INVERT, 0, 0);
		add_cmd(mfb_pkg::ACT_HLINE, -32768, 33, 32767, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_BLACK, SCR_W + 5, 0);
		add_cmd(mfb_pkg::ACT_VLINE, 3, 5, 14, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_BLACK, 2 * SCR_W + 3, 0);
		add_cmd(mfb_pkg::ACT_VLINE, -1, 0, 10, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_VLINE, SCR_W, 0, 10, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_VLINE, 10, 5, -3, mfb_pkg::COLOR_WHITE, 0, 0);
		add_cmd(mfb_pkg::ACT_VLINE, SCR_W - 1, -100, 32767, mfb_pkg::COLOR_INVERT, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, 3, 6, 0, COLOR_NONE, 0, 0);
		add_cmd(mfb_pkg::ACT_PIXEL, 3, 5, 0, mfb_pkg::COLOR_BLACK, 0, 0);
		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_WHITE, 3, 0);
		for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
			add_cmd(3'(a), 1, 1, 1, mfb_pkg::COLOR_WHITE, 3, 0);
		add_cmd(mfb_pkg::ACT_CLEAR, 0, 0, 0, mfb_pkg::COLOR_WHITE, 0, 1);
		add_cmd(mfb_pkg::ACT_READ, 0, 0, 0, mfb_pkg::COLOR_WHITE, STORE_BYTES - 1, 0);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			r = $urandom_range(0, 199);
			if (r < 50)
				act = mfb_pkg::ACT_PIXEL;
			else if (r < 90)
				act = mfb_pkg::ACT_HLINE;
			else if (r < 130)
				act = mfb_pkg::ACT_VLINE;
			else if (r < 132)
				act = mfb_pkg::ACT_CLEAR;
			else if (r < 136)
				act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
			else
				act = mfb_pkg::ACT_READ;
			col = ($urandom_range(0, 19) == 0) ? COLOR_NONE :
				2'($urandom_range(mfb_pkg::COLOR_BLACK, mfb_pkg::COLOR_INVERT));
			add_cmd(act, rand_span(-20, SCR_W + 20), rand_span(-12, SCR_H + 12),
				(act == mfb_pkg::ACT_VLINE) ? rand_span(-4, SCR_H + 8) :
				rand_span(-8, SCR_W + 16), col, $urandom_range(0, 1023), n % 300 == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || start || read_expect.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && read_expect.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/mfb_pkg.sv
sv/mfb_ram.sv
sv/mfb_seq.sv
sv/mono_framebuffer_draw_engine.sv
verif/mono_framebuffer_draw_engine_tb.sv
